>>> hdl/glzw_pkg.sv
// ----------------------------------------------------------------------------
// glzw_pkg: shared types and constants of the GIF LZW code packer
// Field widths, reset values, transaction structs between the front end,
// the dictionary engine and the bit packer, and code-size helpers.
// ----------------------------------------------------------------------------
package glzw_pkg;

	localparam int CFG_W     = 4;
	localparam int PIX_W     = 8;
	localparam int CODE_W    = 12;
	localparam int CW_W      = 4;
	localparam int NFC_W     = 13;
	localparam int DICT_AW   = CODE_W + PIX_W;
	localparam int ACC_W     = 19;
	localparam int FILL_W    = 5;
	localparam int BATCH_N   = 4;
	localparam int CQ_DEPTH  = 8;
	localparam int FQ_DEPTH  = 4;
	localparam int BQ_DEPTH  = 4;

	localparam int MAX_CODES_DEF       = 4096;
	localparam int SUB_BLOCK_BYTES_DEF = 255;

	localparam logic [CFG_W-1:0] CFG_RESET   = 4'd8;
	localparam logic [CFG_W-1:0] MIN_SIZE_LO = 4'd2;
	localparam logic [CFG_W-1:0] MIN_SIZE_HI = 4'd8;
	localparam logic [CW_W-1:0]  CW_MAX      = CW_W'(CODE_W);

	localparam logic [CODE_W-1:0] PREFIX_RESET = '0;
	localparam logic [CW_W-1:0]   CW_RESET     = CW_W'(CFG_RESET + 1);
	localparam logic [NFC_W-1:0]  NFC_RESET    = NFC_W'((1 << CFG_RESET) + 2);

	typedef struct packed {
		logic [PIX_W-1:0] sym;
		logic             last;
	} pix_t;

	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic [CW_W-1:0]   width;
		logic              eof;
	} code_ent_t;

	typedef struct packed {
		logic [2:0]                count;
		code_ent_t [BATCH_N-1:0]   ent;
	} code_batch_t;

	// clamp the code size register to its legal range
	function automatic logic [CFG_W-1:0] eff_size(input logic [CFG_W-1:0] m);
		logic [CFG_W-1:0] r;
		r = m;
		if (m < MIN_SIZE_LO) r = MIN_SIZE_LO;
		if (m > MIN_SIZE_HI) r = MIN_SIZE_HI;
		return r;
	endfunction

	function automatic logic [PIX_W:0] clear_code(input logic [CFG_W-1:0] m_eff);
		return (PIX_W+1)'(1) << m_eff;
	endfunction

	function automatic logic [PIX_W-1:0] sym_mask(input logic [CFG_W-1:0] m_eff);
		logic [PIX_W:0] c;
		c = clear_code(m_eff) - 1'b1;
		return c[PIX_W-1:0];
	endfunction

endpackage

>>> hdl/glzw_front.sv
// ----------------------------------------------------------------------------
// glzw_front: pixel intake
// Accepts pixel transactions, masks the index down to the code size and
// holds them in a short queue for the dictionary engine.
// ----------------------------------------------------------------------------
module glzw_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [glzw_pkg::CFG_W-1:0]  min_code_size,
	input  logic                        push,
	output logic                        full,
	input  logic [glzw_pkg::PIX_W-1:0]  pixel_index,
	input  logic                        last_pixel,
	output logic                        pix_valid,
	output glzw_pkg::pix_t              pix,
	input  logic                        pix_pop
);

	localparam int AW = $clog2(glzw_pkg::FQ_DEPTH);

	glzw_pkg::pix_t        fq_q [glzw_pkg::FQ_DEPTH];
	logic [AW-1:0]         wr_q;
	logic [AW-1:0]         rd_q;
	logic [AW:0]           cnt_q;
	logic                  do_push;
	glzw_pkg::pix_t        new_pix;
	logic [glzw_pkg::CFG_W-1:0] m_eff;

	assign m_eff   = glzw_pkg::eff_size(min_code_size);
	assign full    = (cnt_q == (AW+1)'(glzw_pkg::FQ_DEPTH));
	assign do_push = push && !full;
	assign new_pix = '{sym: pixel_index & glzw_pkg::sym_mask(m_eff), last: last_pixel};

	assign pix_valid = (cnt_q != '0);
	assign pix       = fq_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) fq_q[wr_q] <= new_pix;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= wr_q + 1'b1;
			if (pix_pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(do_push) - (AW+1)'(pix_pop);
		end
	end

endmodule

>>> hdl/glzw_engine.sv
// ----------------------------------------------------------------------------
// glzw_engine: LZW dictionary engine
// Looks up (prefix, symbol) in the dictionary, checks the hit against the
// reverse code table, updates prefix, width and free code, and hands up to
// four codes per pixel to the packer.
// ----------------------------------------------------------------------------
module glzw_engine #(
	parameter int MAX_CODES = glzw_pkg::MAX_CODES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [glzw_pkg::CFG_W-1:0]  min_code_size,
	input  logic                        pix_valid,
	input  glzw_pkg::pix_t              pix,
	output logic                        pix_pop,
	input  logic                        code_room,
	output glzw_pkg::code_batch_t       batch
);

	localparam int CODE_W  = glzw_pkg::CODE_W;
	localparam int NFC_W   = glzw_pkg::NFC_W;
	localparam int DICT_AW = glzw_pkg::DICT_AW;
	localparam int CW_W    = glzw_pkg::CW_W;
	localparam int REV_AW  = $clog2(MAX_CODES);
	localparam logic [NFC_W-1:0] MaxCodesC = NFC_W'(MAX_CODES);

	// dictionary: code of each (prefix, symbol); reverse table: owner of each code
	logic [CODE_W-1:0]  dict_mem [2**DICT_AW];
	logic [DICT_AW-1:0] rev_mem  [MAX_CODES];

	logic                 v_s1, v_s2;
	logic [DICT_AW-1:0]   idx_s1, idx_s2;
	glzw_pkg::pix_t       pix_s1, pix_s2;
	logic                 fwd_s1;
	logic [CODE_W-1:0]    fwd_code_s1;
	logic [CODE_W-1:0]    dict_rd_s1;
	logic [CODE_W-1:0]    c_s2;
	logic [DICT_AW-1:0]   rev_rd_s2;

	logic [CODE_W-1:0]    prefix_q, prefix_d, prefix_new;
	logic [CW_W-1:0]      cw_q, cw_d;
	logic [NFC_W-1:0]     nfc_q, nfc_d;
	logic [NFC_W-1:0]     base_q, base_d;
	logic                 started_q, started_d;

	logic [glzw_pkg::CFG_W-1:0] m_eff;
	logic [NFC_W-1:0]     clr13, nfc_init;
	logic [CODE_W-1:0]    clr_code, end_code, sym_s2;
	logic [CW_W-1:0]      cw_init;
	logic                 hit, d_fire, dict_we, wr_fire;
	logic [2:0]           n_codes;
	glzw_pkg::code_ent_t [glzw_pkg::BATCH_N-1:0] ents;
	logic [DICT_AW-1:0]   rd_addr;
	logic [CODE_W-1:0]    rev_addr;

	assign m_eff    = glzw_pkg::eff_size(min_code_size);
	assign clr13    = NFC_W'(glzw_pkg::clear_code(m_eff));
	assign clr_code = clr13[CODE_W-1:0];
	assign end_code = clr_code + 1'b1;
	assign nfc_init = clr13 + NFC_W'(2);
	assign cw_init  = m_eff + 1'b1;
	assign sym_s2   = {{(CODE_W-glzw_pkg::PIX_W){1'b0}}, pix_s2.sym};

	// an entry is live only if its code was handed out in this table epoch
	// and the reverse table still names this (prefix, symbol) as its owner
	always_comb begin
		hit = 1'b0;
		if (({1'b0, c_s2} >= base_q) && ({1'b0, c_s2} < nfc_q)) begin
			if (rev_rd_s2 == idx_s2) hit = 1'b1;
		end
	end

	assign d_fire  = v_s2 && code_room;
	assign wr_fire = d_fire && dict_we;

	always_comb begin
		prefix_d  = prefix_q;
		cw_d      = cw_q;
		nfc_d     = nfc_q;
		base_d    = base_q;
		started_d = started_q;
		dict_we   = 1'b0;
		n_codes   = '0;
		ents      = '0;
		if (!started_q) begin
			cw_d      = cw_init;
			nfc_d     = nfc_init;
			base_d    = nfc_init;
			ents[0]   = '{code: clr_code, width: cw_init, eof: 1'b0};
			n_codes   = 3'd1;
			prefix_d  = sym_s2;
			started_d = 1'b1;
		end else if (hit) begin
			prefix_d = c_s2;
		end else begin
			ents[0] = '{code: prefix_q, width: cw_q, eof: 1'b0};
			n_codes = 3'd1;
			if (nfc_q < MaxCodesC) begin
				dict_we = 1'b1;
				nfc_d   = nfc_q + 1'b1;
				if ((cw_q < glzw_pkg::CW_MAX) && (nfc_d > (NFC_W'(1) << cw_q)))
					cw_d = cw_q + 1'b1;
			end else begin
				// table full: send clear at the current width and open a new epoch
				ents[1] = '{code: clr_code, width: cw_q, eof: 1'b0};
				n_codes = 3'd2;
				cw_d    = cw_init;
				nfc_d   = nfc_init;
				base_d  = nfc_init;
			end
			prefix_d = sym_s2;
		end
		if (pix_s2.last) begin
			ents[n_codes[1:0]]        = '{code: prefix_d, width: cw_d, eof: 1'b0};
			ents[n_codes[1:0] + 2'd1] = '{code: end_code, width: cw_d, eof: 1'b1};
			n_codes   = n_codes + 3'd2;
			prefix_d  = '0;
			cw_d      = cw_init;
			nfc_d     = nfc_init;
			base_d    = nfc_init;
			started_d = 1'b0;
		end
	end

	assign batch.count = d_fire ? n_codes : 3'd0;
	assign batch.ent   = ents;

	// next lookup may start in the same cycle the current pixel resolves
	assign pix_pop    = pix_valid && !v_s1 && (!v_s2 || d_fire);
	assign prefix_new = d_fire ? prefix_d : prefix_q;
	assign rd_addr    = {prefix_new, pix.sym};
	// a write landing on the address being read this edge is forwarded
	assign rev_addr   = fwd_s1 ? fwd_code_s1 : dict_rd_s1;

	always_ff @(posedge clk) begin
		if (wr_fire) begin
			dict_mem[idx_s2]               <= nfc_q[CODE_W-1:0];
			rev_mem[nfc_q[REV_AW-1:0]]     <= idx_s2;
		end
		if (pix_pop) dict_rd_s1 <= dict_mem[rd_addr];
		if (v_s1) rev_rd_s2 <= rev_mem[rev_addr[REV_AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (pix_pop) begin
			idx_s1      <= rd_addr;
			pix_s1      <= pix;
			fwd_s1      <= wr_fire && (idx_s2 == rd_addr);
			fwd_code_s1 <= nfc_q[CODE_W-1:0];
		end
		if (v_s1) begin
			idx_s2 <= idx_s1;
			pix_s2 <= pix_s1;
			c_s2   <= rev_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			prefix_q  <= glzw_pkg::PREFIX_RESET;
			cw_q      <= glzw_pkg::CW_RESET;
			nfc_q     <= glzw_pkg::NFC_RESET;
			base_q    <= glzw_pkg::NFC_RESET;
			started_q <= 1'b0;
		end else begin
			v_s1 <= pix_pop;
			v_s2 <= v_s1 || (v_s2 && !d_fire);
			if (d_fire) begin
				prefix_q  <= prefix_d;
				cw_q      <= cw_d;
				nfc_q     <= nfc_d;
				base_q    <= base_d;
				started_q <= started_d;
			end
		end
	end

endmodule

>>> hdl/glzw_packer.sv
// ----------------------------------------------------------------------------
// glzw_packer: code-to-byte packer
// Queues codes from the engine, packs them LSB first into bytes, counts
// sub-block bytes, flushes the partial byte at frame end and queues results.
// ----------------------------------------------------------------------------
module glzw_packer #(
	parameter int SUB_BLOCK_BYTES = glzw_pkg::SUB_BLOCK_BYTES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  glzw_pkg::code_batch_t       batch,
	output logic                        code_room,
	output logic                        empty,
	input  logic                        pop,
	output logic [7:0]                  code_byte,
	output logic                        sub_block_end,
	output logic                        last_byte
);

	localparam int CQ_AW   = $clog2(glzw_pkg::CQ_DEPTH);
	localparam int BQ_AW   = $clog2(glzw_pkg::BQ_DEPTH);
	localparam int ACC_W   = glzw_pkg::ACC_W;
	localparam int FILL_W  = glzw_pkg::FILL_W;
	localparam int CHUNK_W = $clog2(SUB_BLOCK_BYTES + 1);
	localparam logic [CHUNK_W-1:0] SubBytesC = CHUNK_W'(SUB_BLOCK_BYTES);

	typedef struct packed {
		logic [7:0] data;
		logic       sbe;
		logic       last;
	} byte_ent_t;

	glzw_pkg::code_ent_t  cq_q [glzw_pkg::CQ_DEPTH];
	logic [CQ_AW-1:0]     cq_wr_q, cq_rd_q;
	logic [CQ_AW:0]       cq_cnt_q;

	byte_ent_t            bq_q [glzw_pkg::BQ_DEPTH];
	logic [BQ_AW-1:0]     bq_wr_q, bq_rd_q;
	logic [BQ_AW:0]       bq_cnt_q;

	logic [ACC_W-1:0]     acc_q;
	logic [FILL_W-1:0]    fill_q;
	logic                 flush_q;
	logic [CHUNK_W-1:0]   chunk_q, chunk_inc;

	glzw_pkg::code_ent_t  head;
	logic [glzw_pkg::CODE_W-1:0] code_m;
	logic [glzw_pkg::CODE_W:0]   mask_w;
	logic                 bq_full, emit_want, do_emit, do_absorb, is_last, sbe, pop_ok;

	assign code_room = (cq_cnt_q <= (CQ_AW+1)'(glzw_pkg::CQ_DEPTH - glzw_pkg::BATCH_N));

	assign head      = cq_q[cq_rd_q];
	assign mask_w    = ((glzw_pkg::CODE_W+1)'(1) << head.width) - 1'b1;
	assign code_m    = head.code & mask_w[glzw_pkg::CODE_W-1:0];

	assign bq_full   = (bq_cnt_q == (BQ_AW+1)'(glzw_pkg::BQ_DEPTH));
	// drain whole bytes first; during a flush the partial byte goes out too
	assign emit_want = (fill_q >= FILL_W'(8)) || (flush_q && (fill_q != '0));
	assign do_emit   = emit_want && !bq_full;
	assign do_absorb = !emit_want && (cq_cnt_q != '0);
	assign is_last   = flush_q && (fill_q <= FILL_W'(8));
	assign chunk_inc = chunk_q + 1'b1;
	assign sbe       = is_last || (chunk_inc >= SubBytesC);

	assign empty         = (bq_cnt_q == '0);
	assign pop_ok        = pop && !empty;
	assign code_byte     = bq_q[bq_rd_q].data;
	assign sub_block_end = bq_q[bq_rd_q].sbe;
	assign last_byte     = bq_q[bq_rd_q].last;

	always_ff @(posedge clk) begin
		for (int j = 0; j < glzw_pkg::BATCH_N; j++) begin
			if (3'(j) < batch.count) cq_q[cq_wr_q + CQ_AW'(j)] <= batch.ent[j];
		end
		if (do_emit) bq_q[bq_wr_q] <= '{data: acc_q[7:0], sbe: sbe, last: is_last};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cq_wr_q  <= '0;
			cq_rd_q  <= '0;
			cq_cnt_q <= '0;
			bq_wr_q  <= '0;
			bq_rd_q  <= '0;
			bq_cnt_q <= '0;
			acc_q    <= '0;
			fill_q   <= '0;
			flush_q  <= 1'b0;
			chunk_q  <= '0;
		end else begin
			cq_wr_q  <= cq_wr_q + CQ_AW'(batch.count);
			cq_cnt_q <= cq_cnt_q + (CQ_AW+1)'(batch.count) - (CQ_AW+1)'(do_absorb);
			if (do_absorb) begin
				cq_rd_q <= cq_rd_q + 1'b1;
				acc_q   <= acc_q | (ACC_W'(code_m) << fill_q);
				fill_q  <= fill_q + FILL_W'(head.width);
				flush_q <= head.eof;
			end
			if (do_emit) begin
				bq_wr_q <= bq_wr_q + 1'b1;
				if (is_last) begin
					acc_q   <= '0;
					fill_q  <= '0;
					flush_q <= 1'b0;
					chunk_q <= '0;
				end else begin
					acc_q   <= acc_q >> 8;
					fill_q  <= fill_q - FILL_W'(8);
					chunk_q <= sbe ? '0 : chunk_inc;
				end
			end
			if (pop_ok) bq_rd_q <= bq_rd_q + 1'b1;
			bq_cnt_q <= bq_cnt_q + (BQ_AW+1)'(do_emit) - (BQ_AW+1)'(pop_ok);
		end
	end

endmodule

>>> hdl/gif_lzw_code_packer.sv
// ----------------------------------------------------------------------------
// gif_lzw_code_packer: variable-width GIF LZW encoder with LSB-first packing
// The pixel rate is set by the dictionary read followed by the reverse code table
// read, whose hit decision feeds the next lookup address: the next pixel is taken
// only as the current one resolves. A pixel reaches the result queue through the
// front queue, both table reads, the code queue and the bit accumulator.
// Reset: arst_n clears all queues and encoder state at once; the dictionary needs
// no clearing pass, since entries are validated by code epoch and reverse table.
// ----------------------------------------------------------------------------
module gif_lzw_code_packer #(
	parameter int MAX_CODES       = glzw_pkg::MAX_CODES_DEF,
	parameter int SUB_BLOCK_BYTES = glzw_pkg::SUB_BLOCK_BYTES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [glzw_pkg::CFG_W-1:0]  cfg_wdata,
	input  logic                        push,
	output logic                        full,
	input  logic [glzw_pkg::PIX_W-1:0]  pixel_index,
	input  logic                        last_pixel,
	output logic                        empty,
	input  logic                        pop,
	output logic [7:0]                  code_byte,
	output logic                        sub_block_end,
	output logic                        last_byte
);

	logic [glzw_pkg::CFG_W-1:0] min_code_size_q;
	logic                       pix_valid;
	logic                       pix_pop;
	glzw_pkg::pix_t             pix;
	logic                       code_room;
	glzw_pkg::code_batch_t      batch;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_code_size_q <= glzw_pkg::CFG_RESET;
		end else if (cfg_we) begin
			min_code_size_q <= cfg_wdata;
		end
	end

	glzw_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.min_code_size (min_code_size_q),
		.push          (push),
		.full          (full),
		.pixel_index   (pixel_index),
		.last_pixel    (last_pixel),
		.pix_valid     (pix_valid),
		.pix           (pix),
		.pix_pop       (pix_pop)
	);

	glzw_engine #(
		.MAX_CODES (MAX_CODES)
	) u_engine (
		.clk           (clk),
		.arst_n        (arst_n),
		.min_code_size (min_code_size_q),
		.pix_valid     (pix_valid),
		.pix           (pix),
		.pix_pop       (pix_pop),
		.code_room     (code_room),
		.batch         (batch)
	);

	glzw_packer #(
		.SUB_BLOCK_BYTES (SUB_BLOCK_BYTES)
	) u_packer (
		.clk           (clk),
		.arst_n        (arst_n),
		.batch         (batch),
		.code_room     (code_room),
		.empty         (empty),
		.pop           (pop),
		.code_byte     (code_byte),
		.sub_block_end (sub_block_end),
		.last_byte     (last_byte)
	);

	a_batch_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		(batch.count != 3'd0) |-> code_room)
		else $error("code batch pushed without queue room");

	a_batch_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		batch.count <= 3'(glzw_pkg::BATCH_N))
		else $error("code batch larger than the queue write width");

	a_pop_needs_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		pix_pop |-> pix_valid)
		else $error("engine took a pixel from an empty front queue");

	a_last_closes_block: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && last_byte) |-> sub_block_end)
		else $error("frame end byte does not close its sub-block");

endmodule

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench of the GIF LZW code packer
// A clocked driver feeds pixels from a pending queue and a clocked monitor
// predicts the packed code bytes of every accepted pixel, then compares each
// popped byte with the oldest prediction. Covers every effective code size
// (clamped settings too), single-pixel frames, a long frame that crosses a
// sub-block end, a code size change mid-frame and back pressure.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int DRAIN_CYCLES = 20;
	localparam int HOLD_CYCLES  = 400;
	localparam int CYCLE_LIMIT  = 3_000_000;

	typedef struct packed {
		logic [7:0] data;
		logic       blk_end;
		logic       frm_end;
	} code_byte_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        cfg_we = 1'b0;
	logic [glzw_pkg::CFG_W-1:0]  cfg_wdata = '0;
	logic                        push = 1'b0;
	logic                        full;
	logic [glzw_pkg::PIX_W-1:0]  pixel_index = '0;
	logic                        last_pixel = 1'b0;
	logic                        empty;
	logic                        pop = 1'b0;
	logic [7:0]                  code_byte;
	logic                        sub_block_end;
	logic                        last_byte;

	// stimulus and expectations
	glzw_pkg::pix_t pix_pending[$];
	code_byte_t     bytes_due[$];
	code_byte_t     step_bytes[$];

	// encoder shadow state
	logic [11:0]                lzw_dict[int];
	logic [glzw_pkg::CFG_W-1:0] size_reg = glzw_pkg::CFG_RESET;
	logic [11:0]                prefix = '0;
	logic [3:0]                 width = 4'd9;
	logic [12:0]                next_code = 13'd258;
	logic [18:0]                acc = '0;
	logic [4:0]                 acc_fill = '0;
	int                         blk_count = 0;
	bit                         in_frame = 1'b0;

	bit pix_taken = 1'b0;
	bit byte_taken = 1'b0;
	bit burst_mode = 1'b0;
	int tx_gap = 0;
	int rx_gap = 0;
	int rx_hold = 0;
	int hold_requests = 0;
	int holds_served = 0;
	int cycles = 0;
	int fail_count = 0;
	int pixels_sent = 0;
	int frames_done = 0;
	int bytes_checked = 0;
	int table_resets = 0;

	gif_lzw_code_packer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.push          (push),
		.full          (full),
		.pixel_index   (pixel_index),
		.last_pixel    (last_pixel),
		.empty         (empty),
		.pop           (pop),
		.code_byte     (code_byte),
		.sub_block_end (sub_block_end),
		.last_byte     (last_byte)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int size_eff(input logic [glzw_pkg::CFG_W-1:0] v);
		if (v < 2) return 2;
		if (v > 8) return 8;
		return int'(v);
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (burst_mode || r < 60) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic put_byte(input logic [7:0] b);
		code_byte_t e;
		blk_count++;
		e.data = b;
		e.blk_end = 1'b0;
		e.frm_end = 1'b0;
		if (blk_count >= glzw_pkg::SUB_BLOCK_BYTES_DEF) begin
			e.blk_end = 1'b1;
			blk_count = 0;
		end
		step_bytes = {step_bytes, e};
	endtask

	task automatic put_code(input logic [11:0] code);
		int w;
		logic [11:0] mask;
		w = (width > 12) ? 12 : int'(width);
		mask = (12'd1 << w) - 12'd1;
		acc = acc | ({7'd0, code & mask} << acc_fill);
		acc_fill = acc_fill + 5'(w);
		while (acc_fill >= 8) begin
			put_byte(acc[7:0]);
			acc = acc >> 8;
			acc_fill = acc_fill - 5'd8;
		end
	endtask

	// advance the shadow encoder by one pixel and queue the bytes it yields
	task automatic encode_pixel(input logic [7:0] pix, input logic last);
		int m;
		int clr;
		int key;
		logic [11:0] sym;
		m = size_eff(size_reg);
		clr = 1 << m;
		sym = 12'(pix & 8'(clr - 1));
		step_bytes.delete();
		if (!in_frame) begin
			width = 4'(m + 1);
			next_code = 13'(clr + 2);
			put_code(12'(clr));
			prefix = sym;
			in_frame = 1'b1;
		end else begin
			key = (int'(prefix) << 8) | int'(sym);
			if (lzw_dict.exists(key)) begin
				prefix = lzw_dict[key];
			end else begin
				put_code(prefix);
				if (next_code < glzw_pkg::MAX_CODES_DEF) begin
					lzw_dict[key] = next_code[11:0];
					next_code++;
					if (width < 12 && next_code > (13'd1 << width)) width++;
				end else begin
					put_code(12'(clr));
					lzw_dict.delete();
					width = 4'(m + 1);
					next_code = 13'(clr + 2);
					table_resets++;
				end
				prefix = sym;
			end
		end
		if (last) begin
			put_code(prefix);
			put_code(12'(clr + 1));
			if (acc_fill > 0) put_byte(acc[7:0]);
			step_bytes[step_bytes.size()-1].blk_end = 1'b1;
			step_bytes[step_bytes.size()-1].frm_end = 1'b1;
			lzw_dict.delete();
			prefix = '0;
			width = 4'(m + 1);
			next_code = 13'(clr + 2);
			acc = '0;
			acc_fill = '0;
			blk_count = 0;
			in_frame = 1'b0;
			frames_done++;
		end
		foreach (step_bytes[i]) bytes_due = {bytes_due, step_bytes[i]};
	endtask

	// monitor: sample both sides, predict on input transactions, check outputs
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end else begin
			pix_taken = arst_n && push && !full;
			byte_taken = arst_n && pop && !empty;
			if (cfg_we) size_reg = cfg_wdata;
			if (pix_taken) begin
				pixels_sent++;
				encode_pixel(pixel_index, last_pixel);
			end
			if (byte_taken) begin
				if (bytes_due.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected byte %h end=%b last=%b at cycle %0d",
							code_byte, sub_block_end, last_byte, cycles);
				end else begin
					if (code_byte !== bytes_due[0].data ||
						sub_block_end !== bytes_due[0].blk_end ||
						last_byte !== bytes_due[0].frm_end) begin
						fail_count++;
						if (fail_count <= 10)
							$display("byte %0d: expected %h/%b/%b got %h/%b/%b",
								bytes_checked, bytes_due[0].data, bytes_due[0].blk_end,
								bytes_due[0].frm_end, code_byte, sub_block_end, last_byte);
					end
					bytes_checked++;
					void'(bytes_due.pop_front());
				end
			end
		end
	end

	// driver: hold the item until its transaction, then idle for a random gap
	always @(negedge clk) begin
		if (arst_n) begin
			if (pix_taken) begin
				void'(pix_pending.pop_front());
				tx_gap = pick_gap();
			end
			if (tx_gap > 0) begin
				tx_gap--;
				push <= 1'b0;
			end else if (pix_pending.size() > 0) begin
				push <= 1'b1;
				pixel_index <= pix_pending[0].sym;
				last_pixel <= pix_pending[0].last;
			end else begin
				push <= 1'b0;
			end
		end
	end

	// receiver: random pop gaps, plus long hold-offs on request
	always @(negedge clk) begin
		if (arst_n) begin
			if (byte_taken) rx_gap = pick_gap();
			if (holds_served < hold_requests) begin
				holds_served++;
				rx_hold = HOLD_CYCLES;
			end
			if (rx_hold > 0) begin
				rx_hold--;
				pop <= 1'b0;
			end else if (rx_gap > 0) begin
				rx_gap--;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	task automatic add_pixel(input logic [7:0] pix, input logic last);
		glzw_pkg::pix_t p;
		p.sym = pix;
		p.last = last;
		pix_pending = {pix_pending, p};
	endtask

	task automatic wait_idle();
		while (pix_pending.size() != 0 || push) @(posedge clk);
		while (bytes_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_size(input logic [glzw_pkg::CFG_W-1:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// frames of mostly repetitive symbols with noise in the ignored upper bits
	task automatic add_random_pixels(input int budget,
		input logic [glzw_pkg::CFG_W-1:0] setting, input bit close_last);
		int n;
		int len;
		logic [7:0] mask;
		logic [7:0] pix;
		n = 0;
		mask = 8'((1 << size_eff(setting)) - 1);
		while (n < budget) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
			if (n + len > budget) len = budget - n;
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(0, 9) < 7)
					pix = (8'($urandom_range(0, 3)) & mask) | (8'($urandom) & ~mask);
				else
					pix = 8'($urandom);
				add_pixel(pix, (i == len - 1) && (close_last || n + len < budget));
			end
			n += len;
		end
	endtask

	initial begin
		int sizes[9];
		sizes = '{3, 8, 2, 5, 1, 12, 7, 4, 6};
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset code size: single pixels at both extremes, repeats that hit
		add_pixel(8'hFF, 1'b1);
		add_pixel(8'h00, 1'b1);
		for (int i = 0; i < 5; i++) add_pixel(8'h5A, i == 4);
		for (int i = 0; i < 6; i++) add_pixel(i[0] ? 8'h02 : 8'h01, i == 5);
		wait_idle();
		write_size(4'd2);
		add_pixel(8'hFF, 1'b0);
		add_pixel(8'hFC, 1'b0);
		add_pixel(8'h03, 1'b0);
		add_pixel(8'h00, 1'b1);
		wait_idle();
		// out-of-range sizes clamp to the nearest legal one
		write_size(4'd0);
		add_pixel(8'h07, 1'b0);
		add_pixel(8'h07, 1'b1);
		wait_idle();
		write_size(4'd15);
		add_pixel(8'hFF, 1'b1);
		wait_idle();
		write_size(4'd9);
		add_pixel(8'h80, 1'b0);
		add_pixel(8'h80, 1'b1);
		wait_idle();
		write_size(4'd1);
		add_pixel(8'hFE, 1'b1);
		wait_idle();

		// one long noisy frame: spans a sub-block end under a long hold-off
		write_size(4'd8);
		hold_requests++;
		burst_mode = 1'b1;
		for (int i = 0; i < 240; i++) add_pixel(8'($urandom), i == 239);
		while (pix_pending.size() > 120) @(posedge clk);
		burst_mode = 1'b0;
		wait_idle();

		// random frames per setting; the fifth phase leaves its frame open
		foreach (sizes[j]) begin
			write_size(4'(sizes[j]));
			if (j == 2) hold_requests++;
			add_random_pixels(20, 4'(sizes[j]), j != 4);
			wait_idle();
		end

		$display("covered %0d pixels in %0d frames, %0d code bytes checked",
			pixels_sent, frames_done, bytes_checked);
		$display("full-table dictionary resets: %0d, failures: %0d",
			table_resets, fail_count);
		if (fail_count == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule
